/* hdl/phcc_pkg.sv */
// Shared widths, types and constants of the pixel hit clustering block.
package phcc_pkg;

    localparam int MAX_HITS_DEF   = 64;
    localparam int COORD_BITS_DEF = 10;

    localparam int COL_W   = 10;
    localparam int CHG_W   = 16;
    localparam int TIME_W  = 48;
    localparam int SIZE_W  = 7;
    localparam int CSUM_W  = 16;                // up to 64 coordinates of 10 bits
    localparam int PROD_W  = COL_W + CHG_W;     // coordinate times charge
    localparam int WSUM_W  = PROD_W + 6;        // up to 64 products
    localparam int QSUM_W  = 22;
    localparam int FRAC_W  = 8;
    localparam int NUM_W   = WSUM_W + FRAC_W;
    localparam int DEN_W   = QSUM_W;
    localparam int Q_W     = 18;

    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 120;

    // One stored hit
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [COL_W-1:0]  row;
        logic [CHG_W-1:0]  charge;
        logic [TIME_W-1:0] tstamp;
    } hit_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic             load;
        logic [COL_W-1:0] load_col;
        logic [COL_W-1:0] load_row;
        logic             seed_req;
        logic             grow_req;
        logic             probe_valid;
        logic [COL_W-1:0] probe_col;
        logic [COL_W-1:0] probe_row;
        logic             clear;
    } ctrl_t;

    // Priority and data chain handed from cell to cell
    typedef struct packed {
        logic seed_taken;
        logic front_taken;
        hit_t data;
    } chain_t;

endpackage

/* hdl/phcc_cell.sv */
// One hit cell: holds a hit, its flags, and joins the grant and data chain.
module phcc_cell #(
    parameter int COORD_BITS = phcc_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  phcc_pkg::ctrl_t       ctrl,
    input  logic                  load_sel,
    input  phcc_pkg::hit_t        load_hit,
    input  phcc_pkg::chain_t      cin,
    output phcc_pkg::chain_t      cout
);

    logic           valid_reg;
    logic           vis_reg;
    logic           claimed_reg;
    logic           front_reg;
    phcc_pkg::hit_t hit_reg;

    logic                     seed_gnt;
    logic                     front_gnt;
    logic                     gnt;
    logic                     hit_claim;
    logic                     load_kill;
    logic                     in_area;
    logic [phcc_pkg::COL_W:0] dc;
    logic [phcc_pkg::COL_W:0] dr;
    logic                     near_c;
    logic                     near_r;

    // Grant the lowest free cell as seed, the lowest frontier cell as probe
    assign seed_gnt  = ctrl.seed_req & valid_reg & ~claimed_reg & ~cin.seed_taken;
    assign front_gnt = ctrl.grow_req & front_reg & ~cin.front_taken;
    assign gnt       = seed_gnt | front_gnt;

    assign cout.seed_taken  = cin.seed_taken | (valid_reg & ~claimed_reg);
    assign cout.front_taken = cin.front_taken | front_reg;
    assign cout.data        = cin.data | (gnt ? hit_reg : '0);

    // Neighbor test against the probe in flight
    assign dc     = {1'b0, hit_reg.col} - {1'b0, ctrl.probe_col};
    assign dr     = {1'b0, hit_reg.row} - {1'b0, ctrl.probe_row};
    assign near_c = (dc == '0) || (dc == (phcc_pkg::COL_W+1)'(1)) || (dc == '1);
    assign near_r = (dr == '0) || (dr == (phcc_pkg::COL_W+1)'(1)) || (dr == '1);
    assign hit_claim = ctrl.probe_valid & valid_reg & vis_reg & ~claimed_reg & near_c & near_r;

    // A later hit at the same position hides this one
    assign load_kill = ctrl.load & valid_reg & (hit_reg.col == ctrl.load_col)
                       & (hit_reg.row == ctrl.load_row);
    assign in_area = ((load_hit.col >> COORD_BITS) == '0)
                     && ((load_hit.row >> COORD_BITS) == '0);

    // Update flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            vis_reg     <= 1'b0;
            claimed_reg <= 1'b0;
            front_reg   <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg   <= 1'b0;
            claimed_reg <= 1'b0;
            front_reg   <= 1'b0;
        end
        else if (load_sel)
        begin
            valid_reg   <= 1'b1;
            vis_reg     <= in_area;
            claimed_reg <= 1'b0;
            front_reg   <= 1'b0;
        end
        else
        begin
            if (load_kill)
                vis_reg <= 1'b0;
            if (seed_gnt || hit_claim)
                claimed_reg <= 1'b1;
            // The seed is probed from the seed cycle; only grown hits join the frontier
            if (hit_claim)
                front_reg <= 1'b1;
            else if (front_gnt)
                front_reg <= 1'b0;
        end
    end

    // Hold the hit payload
    always_ff @(posedge clk)
    begin
        if (load_sel)
            hit_reg <= load_hit;
    end

endmodule

/* hdl/phcc_divider.sv */
// Restoring divider, one quotient bit per cycle.
module phcc_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [phcc_pkg::NUM_W-1:0] num,
    input  logic [phcc_pkg::DEN_W-1:0] den,
    output logic                       busy,
    output logic                       done,
    output logic [phcc_pkg::Q_W-1:0]   quot
);

    localparam int CNT_W = $clog2(phcc_pkg::NUM_W);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [phcc_pkg::NUM_W-1:0] num_reg;
    logic [phcc_pkg::DEN_W-1:0] den_reg;
    logic [phcc_pkg::DEN_W-1:0] rem_reg;
    logic [phcc_pkg::Q_W-1:0]   quot_reg;

    logic [phcc_pkg::DEN_W:0]   rem_sh;
    logic                       qbit;
    logic [phcc_pkg::DEN_W-1:0] rem_next;

    // Shift in one numerator bit, subtract when it fits
    assign rem_sh   = {rem_reg, num_reg[phcc_pkg::NUM_W-1]};
    assign qbit     = (rem_sh >= {1'b0, den_reg});
    assign rem_next = qbit ? phcc_pkg::DEN_W'(rem_sh - {1'b0, den_reg})
                           : rem_sh[phcc_pkg::DEN_W-1:0];

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(phcc_pkg::NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= num_reg << 1;
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[phcc_pkg::Q_W-2:0], qbit};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* hdl/pixel_hit_clustering_centroid.sv */
// Top level: hit loading, cluster growth over the cell row, centroid and output.
// Hits of one event enter one word per cycle into a row of MAX_HITS cells; the word
// with tlast closes the event and the input stalls until every cluster has been
// formed. Each cluster is then seeded, grown (each member is probed once against all
// cells at the same time), the probe and product stages drained, the column and row
// centroid computed in turn in the shared restoring divider, and the word handed to
// the result register. The result register lets the next cluster be computed, or
// the next event load, while a cluster word waits on m_axis_tready.
// Hits beyond MAX_HITS in an event are dropped; a dropped word with tlast still
// ends the event.
module pixel_hit_clustering_centroid #(
    parameter int MAX_HITS   = phcc_pkg::MAX_HITS_DEF,
    parameter int COORD_BITS = phcc_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,      // weighted centroid enable
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // hit_column, hit_row, hit_charge, hit_time, zero pad
    input  logic [phcc_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tlast,   // last_hit
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // centroid_column_q8, centroid_row_q8, total_charge, cluster_size, cluster_time, pad
    output logic [phcc_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast    // last_cluster
);

    localparam int HC_W = $clog2(MAX_HITS + 1);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_SEED = 3'd1;
    localparam logic [2:0] S_GROW = 3'd2;
    localparam logic [2:0] S_DIVC = 3'd3;
    localparam logic [2:0] S_DIVR = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]      state_reg;
    logic [2:0]      state_next;
    logic [HC_W-1:0] hit_count_reg;
    logic            weight_reg;

    phcc_pkg::ctrl_t  ctrl;
    phcc_pkg::hit_t   in_hit;
    phcc_pkg::chain_t chain [MAX_HITS+1];
    logic [MAX_HITS-1:0] load_sel;
    logic            accept;
    logic            store;

    // probe stage, product stage, accumulators
    logic                        p_valid_reg;
    logic [phcc_pkg::COL_W-1:0]  p_col_reg;
    logic [phcc_pkg::COL_W-1:0]  p_row_reg;
    logic [phcc_pkg::CHG_W-1:0]  p_chg_reg;
    logic                        m_valid_s2_reg;
    logic [phcc_pkg::COL_W-1:0]  s2_col_reg;
    logic [phcc_pkg::COL_W-1:0]  s2_row_reg;
    logic [phcc_pkg::CHG_W-1:0]  s2_chg_reg;
    logic [phcc_pkg::PROD_W-1:0] s2_wc_reg;
    logic [phcc_pkg::PROD_W-1:0] s2_wr_reg;
    logic [phcc_pkg::CSUM_W-1:0] csum_reg;
    logic [phcc_pkg::CSUM_W-1:0] rsum_reg;
    logic [phcc_pkg::QSUM_W-1:0] qsum_reg;
    logic [phcc_pkg::WSUM_W-1:0] wcsum_reg;
    logic [phcc_pkg::WSUM_W-1:0] wrsum_reg;
    logic [phcc_pkg::SIZE_W-1:0] size_reg;
    logic                        zero_reg;
    logic [phcc_pkg::TIME_W-1:0] seed_time_reg;
    logic                        last_reg;
    logic [phcc_pkg::Q_W-1:0]    cc_reg;
    logic [phcc_pkg::Q_W-1:0]    cr_reg;

    logic                        use_weight;
    logic [phcc_pkg::NUM_W-1:0]  num_col;
    logic [phcc_pkg::NUM_W-1:0]  num_row;
    logic [phcc_pkg::DEN_W-1:0]  den;
    logic                        div_start;
    logic [phcc_pkg::NUM_W-1:0]  div_num;
    logic                        div_busy;
    logic                        div_done;
    logic [phcc_pkg::Q_W-1:0]    div_quot;
    logic                        grow_done;
    logic                        out_free;

    logic                        m_valid_reg;
    logic [phcc_pkg::M_DATA_W-1:0] m_data_reg;
    logic                        m_last_reg;

    // Unpack the input word
    assign in_hit.col    = s_axis_tdata[9:0];
    assign in_hit.row    = s_axis_tdata[19:10];
    assign in_hit.charge = s_axis_tdata[35:20];
    assign in_hit.tstamp = s_axis_tdata[83:36];

    assign s_axis_tready = (state_reg == S_LOAD);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign store         = accept & (hit_count_reg < HC_W'(MAX_HITS));

    // Cell control
    assign ctrl.load        = store;
    assign ctrl.load_col    = in_hit.col;
    assign ctrl.load_row    = in_hit.row;
    assign ctrl.seed_req    = (state_reg == S_SEED);
    assign ctrl.grow_req    = (state_reg == S_GROW);
    assign ctrl.probe_valid = p_valid_reg;
    assign ctrl.probe_col   = p_col_reg;
    assign ctrl.probe_row   = p_row_reg;
    assign out_free         = ~m_valid_reg | m_axis_tready;
    assign ctrl.clear       = (state_reg == S_OUT) & out_free & last_reg;

    assign chain[0] = '0;

    // Row of hit cells
    for (genvar k = 0; k < MAX_HITS; k++)
    begin : g_cell
        assign load_sel[k] = accept & (hit_count_reg == HC_W'(k));
        phcc_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .load_sel (load_sel[k]),
            .load_hit (in_hit),
            .cin      (chain[k]),
            .cout     (chain[k+1])
        );
    end

    assign grow_done = ~chain[MAX_HITS].front_taken & ~p_valid_reg & ~m_valid_s2_reg;

    // Centroid operands
    assign use_weight = weight_reg & ~zero_reg & (qsum_reg != '0);
    assign num_col = use_weight ? {wcsum_reg, 8'b0}
                                : phcc_pkg::NUM_W'({csum_reg, 8'b0});
    assign num_row = use_weight ? {wrsum_reg, 8'b0}
                                : phcc_pkg::NUM_W'({rsum_reg, 8'b0});
    assign den     = use_weight ? qsum_reg : phcc_pkg::DEN_W'(size_reg);
    assign div_start = ((state_reg == S_GROW) & grow_done) | ((state_reg == S_DIVC) & div_done);
    assign div_num   = (state_reg == S_GROW) ? num_col : num_row;

    phcc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: if (accept && s_axis_tlast) state_next = S_SEED;
            S_SEED: state_next = S_GROW;
            S_GROW: if (grow_done) state_next = S_DIVC;
            S_DIVC: if (div_done) state_next = S_DIVR;
            S_DIVR: if (div_done) state_next = S_OUT;
            S_OUT:  if (out_free) state_next = last_reg ? S_LOAD : S_SEED;
            default: state_next = S_LOAD;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            hit_count_reg  <= '0;
            weight_reg     <= 1'b1;
            p_valid_reg    <= 1'b0;
            m_valid_s2_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                weight_reg <= cfg_wdata;
            if (store)
                hit_count_reg <= hit_count_reg + HC_W'(1);
            else if (ctrl.clear)
                hit_count_reg <= '0;
            p_valid_reg <= (state_reg == S_SEED)
                           | ((state_reg == S_GROW) & chain[MAX_HITS].front_taken);
            m_valid_s2_reg <= p_valid_reg;
            if ((state_reg == S_OUT) && out_free)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Probe, product and accumulate
    always_ff @(posedge clk)
    begin
        p_col_reg  <= chain[MAX_HITS].data.col;
        p_row_reg  <= chain[MAX_HITS].data.row;
        p_chg_reg  <= chain[MAX_HITS].data.charge;
        s2_col_reg <= p_col_reg;
        s2_row_reg <= p_row_reg;
        s2_chg_reg <= p_chg_reg;
        s2_wc_reg  <= phcc_pkg::PROD_W'(p_col_reg * p_chg_reg);
        s2_wr_reg  <= phcc_pkg::PROD_W'(p_row_reg * p_chg_reg);
        if (state_reg == S_SEED)
        begin
            seed_time_reg <= chain[MAX_HITS].data.tstamp;
            csum_reg  <= '0;
            rsum_reg  <= '0;
            qsum_reg  <= '0;
            wcsum_reg <= '0;
            wrsum_reg <= '0;
            size_reg  <= '0;
            zero_reg  <= 1'b0;
        end
        else if (m_valid_s2_reg)
        begin
            csum_reg  <= csum_reg + phcc_pkg::CSUM_W'(s2_col_reg);
            rsum_reg  <= rsum_reg + phcc_pkg::CSUM_W'(s2_row_reg);
            qsum_reg  <= qsum_reg + phcc_pkg::QSUM_W'(s2_chg_reg);
            wcsum_reg <= wcsum_reg + phcc_pkg::WSUM_W'(s2_wc_reg);
            wrsum_reg <= wrsum_reg + phcc_pkg::WSUM_W'(s2_wr_reg);
            size_reg  <= size_reg + phcc_pkg::SIZE_W'(1);
            if (s2_chg_reg == '0)
                zero_reg <= 1'b1;
        end
        if ((state_reg == S_GROW) && grow_done)
            last_reg <= ~chain[MAX_HITS].seed_taken;
        if ((state_reg == S_DIVC) && div_done)
            cc_reg <= div_quot;
        if ((state_reg == S_DIVR) && div_done)
            cr_reg <= div_quot;
        if ((state_reg == S_OUT) && out_free)
        begin
            m_data_reg <= phcc_pkg::M_DATA_W'({seed_time_reg, size_reg, qsum_reg, cr_reg, cc_reg});
            m_last_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hit_count_reg <= HC_W'(MAX_HITS))
        else $error("hit count beyond cell row");
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIVC || state_reg == S_DIVR))
        else $error("divider busy outside centroid states");
    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[64:58] != '0))
        else $error("empty cluster emitted");
`endif

endmodule
